// ----- rtl/pace_pkg.sv -----
// ----------------------------------------------------------------------------
// pace_pkg: shared types and constants of the pulse actuator and edge counter
// Command codes, field widths and the command struct that is passed from the
// input register to the actuator lanes and the edge counter.
// ----------------------------------------------------------------------------
package pace_pkg;

  localparam int unsigned PACE_FUNC_W = 3;
  localparam int unsigned PACE_ID_W   = 3;
  localparam int unsigned PACE_MS_W   = 16;
  localparam int unsigned PACE_TICK_W = 10;
  localparam int unsigned PACE_CNT_W  = 32;
  localparam int unsigned PACE_RES_W  = 4;

  localparam logic [PACE_TICK_W-1:0] PACE_TICKS_MAX = 10'd1023;
  localparam logic [PACE_ID_W-1:0]   PACE_CNT_ID    = 3'd1;

  typedef enum logic [PACE_FUNC_W-1:0] {
    FUNC_SET     = 3'd0,
    FUNC_TOGGLE  = 3'd1,
    FUNC_PULSE   = 3'd2,
    FUNC_CNT_RST = 3'd3,
    FUNC_TICK    = 3'd4
  } pace_func_e;

  // One command as it leaves the input register. upd marks the cycle in which
  // the command moves into the result register and so updates the state.
  typedef struct packed {
    logic                  upd;
    pace_func_e            func;
    logic [PACE_ID_W-1:0]  target_id;
    logic                  set_level;
    logic [PACE_MS_W-1:0]  pulse_ms;
    logic                  counter_pin;
  } pace_cmd_t;

endpackage

// ----- rtl/pace_actuators.sv -----
// ----------------------------------------------------------------------------
// pace_actuators: actuator output lanes with pulse timers
// Each lane holds an output level and a tick count. The pulse length in ticks
// is the command's millisecond value divided by TICK_MS, clamped to 1..1023.
// ----------------------------------------------------------------------------
module pace_actuators #(
  parameter int unsigned NUM_OUTPUTS = 4,
  parameter int unsigned TICK_MS     = 100
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pace_pkg::pace_cmd_t    cmd_i,
  output logic [NUM_OUTPUTS-1:0] level_next_o,
  output logic [NUM_OUTPUTS-1:0] busy_next_o
);

  // Exact division by a constant: q = (ms * ceil(2^S / TICK_MS)) >> S, with
  // S = 16 + ceil(log2(TICK_MS)), is exact for every 16-bit dividend.
  localparam int unsigned SHIFT  = pace_pkg::PACE_MS_W + $clog2(TICK_MS);
  localparam int unsigned PROD_W = SHIFT + pace_pkg::PACE_MS_W;
  localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT) + longint'(TICK_MS) - 64'd1) / longint'(TICK_MS);
  localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_L);

  logic [PROD_W-1:0]                 prod;
  logic [pace_pkg::PACE_MS_W-1:0]    quot;
  logic [pace_pkg::PACE_TICK_W-1:0]  pulse_ticks;

  always_comb begin
    prod = PROD_W'(cmd_i.pulse_ms) * RECIP;
    quot = prod[SHIFT +: pace_pkg::PACE_MS_W];
    if (quot == '0) begin
      pulse_ticks = pace_pkg::PACE_TICK_W'(1);
    end else if (quot > pace_pkg::PACE_MS_W'(pace_pkg::PACE_TICKS_MAX)) begin
      pulse_ticks = pace_pkg::PACE_TICKS_MAX;
    end else begin
      pulse_ticks = quot[pace_pkg::PACE_TICK_W-1:0];
    end
  end

  for (genvar k = 0; k < NUM_OUTPUTS; k++) begin : g_lane
    logic                             level_q, level_d;
    logic [pace_pkg::PACE_TICK_W-1:0] ticks_q, ticks_d;
    logic                             sel;

    assign sel = (int'(cmd_i.target_id) == k + 1);

    always_comb begin
      level_d = level_q;
      ticks_d = ticks_q;
      if (cmd_i.upd) begin
        case (cmd_i.func)
          pace_pkg::FUNC_SET: begin
            if (sel) begin
              level_d = cmd_i.set_level;
              ticks_d = '0;
            end
          end
          pace_pkg::FUNC_TOGGLE: begin
            if (sel) begin
              level_d = ~level_q;
              ticks_d = '0;
            end
          end
          pace_pkg::FUNC_PULSE: begin
            if (sel) begin
              level_d = 1'b1;
              ticks_d = pulse_ticks;
            end
          end
          pace_pkg::FUNC_TICK: begin
            if (ticks_q > pace_pkg::PACE_TICK_W'(1)) begin
              ticks_d = ticks_q - pace_pkg::PACE_TICK_W'(1);
            end else if (ticks_q == pace_pkg::PACE_TICK_W'(1)) begin
              ticks_d = '0;
              level_d = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        level_q <= 1'b0;
        ticks_q <= '0;
      end else begin
        level_q <= level_d;
        ticks_q <= ticks_d;
      end
    end

    assign level_next_o[k] = level_d;
    assign busy_next_o[k]  = (ticks_d != '0);
  end

endmodule

// ----- rtl/pace_edge_cnt.sv -----
// ----------------------------------------------------------------------------
// pace_edge_cnt: sampled falling-edge counter
// Counts 1-to-0 transitions of the counter pin as seen on tick commands.
// ----------------------------------------------------------------------------
module pace_edge_cnt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pace_pkg::pace_cmd_t             cmd_i,
  output logic [pace_pkg::PACE_CNT_W-1:0] cnt_next_o
);

  logic [pace_pkg::PACE_CNT_W-1:0] cnt_q, cnt_d;
  logic                            last_q, last_d;

  always_comb begin
    cnt_d  = cnt_q;
    last_d = last_q;
    if (cmd_i.upd) begin
      case (cmd_i.func)
        pace_pkg::FUNC_CNT_RST: begin
          if (cmd_i.target_id == pace_pkg::PACE_CNT_ID) begin
            cnt_d  = '0;
            last_d = 1'b1;
          end
        end
        pace_pkg::FUNC_TICK: begin
          if (last_q && !cmd_i.counter_pin) begin
            cnt_d = cnt_q + pace_pkg::PACE_CNT_W'(1);
          end
          last_d = cmd_i.counter_pin;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  assign cnt_next_o = cnt_d;

endmodule

// ----- rtl/pulse_actuator_and_edge_counter.sv -----
// ----------------------------------------------------------------------------
// pulse_actuator_and_edge_counter: pulse-capable actuators and an edge counter
// Top level with the input register, the result register and flow control.
// ----------------------------------------------------------------------------
// Usage: each input beat on the command channel (in_valid_i / in_stall_o)
// carries one command: set, toggle or pulse an actuator, reset the counter,
// or a tick that advances the pulse timers and samples counter_pin_i.
// Every command yields exactly one result beat on the result channel
// (out_valid_o / out_stall_i) that shows the actuator levels, the pulsing
// mask and the event count after the command, plus id_ok_o.
// A beat accepted on the command channel is captured in the input register,
// updates the state and lands in the result register when the held command
// moves on, and is offered on the result channel from then on. Throughput
// is one beat per cycle while the receiver does not stall; the single
// multiply of the pulse-length division sits between the two registers.
// While the receiver stalls, the result register holds its beat and the
// input register still takes one more beat before in_stall_o rises.
// Reset clears all actuator levels and timers, sets the count to zero and
// the remembered pin level to one, and empties both registers.
// ----------------------------------------------------------------------------
module pulse_actuator_and_edge_counter #(
  parameter int unsigned NUM_OUTPUTS = 4,
  parameter int unsigned TICK_MS     = 100
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pace_pkg::PACE_FUNC_W-1:0]    func_i,
  input  logic [pace_pkg::PACE_ID_W-1:0]      target_id_i,
  input  logic                                set_level_i,
  input  logic [pace_pkg::PACE_MS_W-1:0]      pulse_ms_i,
  input  logic                                counter_pin_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pace_pkg::PACE_RES_W-1:0]     actuator_levels_o,
  output logic [pace_pkg::PACE_RES_W-1:0]     pulsing_mask_o,
  output logic [pace_pkg::PACE_CNT_W-1:0]     event_total_o,
  output logic                                id_ok_o
);

  // Input register: one command waiting to be executed.
  logic                s1_valid_q;
  pace_pkg::pace_cmd_t cmd_q;
  pace_pkg::pace_cmd_t cmd;

  // Result register.
  logic                              out_valid_q;
  logic [pace_pkg::PACE_RES_W-1:0]   levels_q, levels_d;
  logic [pace_pkg::PACE_RES_W-1:0]   mask_q, mask_d;
  logic [pace_pkg::PACE_CNT_W-1:0]   total_q;
  logic                              ok_q, ok_d;

  logic                              adv;
  logic                              in_acc;
  logic [NUM_OUTPUTS-1:0]            level_next;
  logic [NUM_OUTPUTS-1:0]            busy_next;
  logic [pace_pkg::PACE_CNT_W-1:0]   cnt_next;
  logic                              act_ok;

  // The held command moves on whenever the result register is empty or its
  // beat is being taken in this cycle.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!s1_valid_q || adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q.upd         <= 1'b0;
      cmd_q.func        <= pace_pkg::pace_func_e'(func_i);
      cmd_q.target_id   <= target_id_i;
      cmd_q.set_level   <= set_level_i;
      cmd_q.pulse_ms    <= pulse_ms_i;
      cmd_q.counter_pin <= counter_pin_i;
    end
  end

  // The state changes exactly when the command enters the result register.
  always_comb begin
    cmd     = cmd_q;
    cmd.upd = s1_valid_q && adv;
  end

  pace_actuators #(
    .NUM_OUTPUTS (NUM_OUTPUTS),
    .TICK_MS     (TICK_MS)
  ) u_actuators (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .level_next_o (level_next),
    .busy_next_o  (busy_next)
  );

  pace_edge_cnt u_edge_cnt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cnt_next_o (cnt_next)
  );

  // Only the first four actuators are visible in the result; with fewer
  // actuators the upper bits read as zero.
  for (genvar k = 0; k < pace_pkg::PACE_RES_W; k++) begin : g_res
    if (k < NUM_OUTPUTS) begin : g_used
      assign levels_d[k] = level_next[k];
      assign mask_d[k]   = busy_next[k];
    end else begin : g_unused
      assign levels_d[k] = 1'b0;
      assign mask_d[k]   = 1'b0;
    end
  end

  // id_ok: a valid actuator id for set, toggle and pulse, the counter id for
  // a counter reset, always for a tick, and never for an unused code.
  assign act_ok = (cmd_q.target_id != '0) && (int'(cmd_q.target_id) <= NUM_OUTPUTS);

  always_comb begin
    case (cmd_q.func)
      pace_pkg::FUNC_SET,
      pace_pkg::FUNC_TOGGLE,
      pace_pkg::FUNC_PULSE:   ok_d = act_ok;
      pace_pkg::FUNC_CNT_RST: ok_d = (cmd_q.target_id == pace_pkg::PACE_CNT_ID);
      pace_pkg::FUNC_TICK:    ok_d = 1'b1;
      default:                ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.upd) begin
      levels_q <= levels_d;
      mask_q   <= mask_d;
      total_q  <= cnt_next;
      ok_q     <= ok_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign actuator_levels_o = levels_q;
  assign pulsing_mask_o    = mask_q;
  assign event_total_o     = total_q;
  assign id_ok_o           = ok_q;

`ifndef SYNTHESIS
  // A held command that cannot advance is still held in the next cycle.
  a_hold_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q)
    else $error("held command was dropped");

  // An actuator with ticks left is always driven high.
  a_pulse_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((pulsing_mask_o & ~actuator_levels_o) == '0))
    else $error("pulsing actuator reported low");

  // A tick always reports a good id.
  a_tick_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.upd && (cmd_q.func == pace_pkg::FUNC_TICK)) |=> id_ok_o)
    else $error("tick result without id_ok");

  // A counter reset shows a zero count in its result.
  a_cnt_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.upd && (cmd_q.func == pace_pkg::FUNC_CNT_RST) &&
     (cmd_q.target_id == pace_pkg::PACE_CNT_ID)) |=> (event_total_o == '0))
    else $error("counter reset left a nonzero count");
`endif

endmodule

// ----- tb/sv/pace_status_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pace_status_checker: predicts and checks the status beats of the block
// Watches the command and status channels, keeps its own copy of the
// actuator levels, pulse timers and edge counter, and compares each status
// beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module pace_status_checker #(
  parameter int unsigned NUM_OUTPUTS = 4,
  parameter int unsigned TICK_MS     = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [pace_pkg::PACE_FUNC_W-1:0] func_i,
  input  logic [pace_pkg::PACE_ID_W-1:0]   target_id_i,
  input  logic                             set_level_i,
  input  logic [pace_pkg::PACE_MS_W-1:0]   pulse_ms_i,
  input  logic                             counter_pin_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [pace_pkg::PACE_RES_W-1:0]  actuator_levels_i,
  input  logic [pace_pkg::PACE_RES_W-1:0]  pulsing_mask_i,
  input  logic [pace_pkg::PACE_CNT_W-1:0]  event_total_i,
  input  logic                             id_ok_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  localparam int unsigned PRINT_LIMIT = 60;

  typedef struct packed {
    logic [pace_pkg::PACE_RES_W-1:0] levels;
    logic [pace_pkg::PACE_RES_W-1:0] pulsing;
    logic [pace_pkg::PACE_CNT_W-1:0] total;
    logic                            id_ok;
  } status_t;

  // Private copy of the block state.
  logic                             act_level   [NUM_OUTPUTS];
  logic [pace_pkg::PACE_TICK_W-1:0] pulse_ticks [NUM_OUTPUTS];
  logic [pace_pkg::PACE_CNT_W-1:0]  edge_total;
  logic                             pin_seen;

  status_t     status_due [$];
  status_t     want;
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] status error, %s: got %0h, predicted %0h", $time, what, got,
               exp_val);
    end
    mismatches++;
  endtask

  // Applies one command to the private state and returns the status that the
  // block must show afterwards.
  function automatic status_t apply_command(
      input logic [pace_pkg::PACE_FUNC_W-1:0] cmd,
      input logic [pace_pkg::PACE_ID_W-1:0]   id,
      input logic                             lvl,
      input logic [pace_pkg::PACE_MS_W-1:0]   ms,
      input logic                             pin);
    status_t     st;
    logic        act_ok;
    int unsigned slot;
    int unsigned span;
    act_ok   = (id >= 1) && (id <= NUM_OUTPUTS);
    slot     = act_ok ? id - 1 : 0;
    st       = '0;
    case (cmd)
      pace_pkg::FUNC_SET: begin
        if (act_ok) begin
          pulse_ticks[slot] = '0;
          act_level[slot]   = lvl;
          st.id_ok          = 1'b1;
        end
      end
      pace_pkg::FUNC_TOGGLE: begin
        if (act_ok) begin
          pulse_ticks[slot] = '0;
          act_level[slot]   = !act_level[slot];
          st.id_ok          = 1'b1;
        end
      end
      pace_pkg::FUNC_PULSE: begin
        if (act_ok) begin
          // A pulse lasts whole ticks, at least one, at most the timer maximum.
          span = ms / TICK_MS;
          if (span < 1) span = 1;
          if (span > pace_pkg::PACE_TICKS_MAX) span = 32'(pace_pkg::PACE_TICKS_MAX);
          act_level[slot]   = 1'b1;
          pulse_ticks[slot] = pace_pkg::PACE_TICK_W'(span);
          st.id_ok          = 1'b1;
        end
      end
      pace_pkg::FUNC_CNT_RST: begin
        if (id == pace_pkg::PACE_CNT_ID) begin
          edge_total = '0;
          pin_seen   = 1'b1;
          st.id_ok   = 1'b1;
        end
      end
      pace_pkg::FUNC_TICK: begin
        for (int k = 0; k < NUM_OUTPUTS; k++) begin
          if (pulse_ticks[k] > 1) begin
            pulse_ticks[k] = pulse_ticks[k] - 1'b1;
          end else if (pulse_ticks[k] == 1) begin
            pulse_ticks[k] = '0;
            act_level[k]   = 1'b0;
          end
        end
        if (pin_seen && !pin) edge_total = edge_total + 1'b1;
        pin_seen = pin;
        st.id_ok = 1'b1;
      end
      default: ;
    endcase
    for (int k = 0; k < NUM_OUTPUTS && k < pace_pkg::PACE_RES_W; k++) begin
      st.levels[k]  = act_level[k];
      st.pulsing[k] = (pulse_ticks[k] != 0);
    end
    st.total = edge_total;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_OUTPUTS; k++) begin
        act_level[k]   = 1'b0;
        pulse_ticks[k] = '0;
      end
      edge_total = '0;
      pin_seen   = 1'b1;
      status_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (status_due.size() == 0) begin
          report_mismatch("status beat with nothing predicted", event_total_i, 0);
        end else begin
          want = status_due.pop_front();
          if (actuator_levels_i !== want.levels)
            report_mismatch("actuator_levels", actuator_levels_i, want.levels);
          if (pulsing_mask_i !== want.pulsing)
            report_mismatch("pulsing_mask", pulsing_mask_i, want.pulsing);
          if (event_total_i !== want.total)
            report_mismatch("event_total", event_total_i, want.total);
          if (id_ok_i !== want.id_ok)
            report_mismatch("id_ok", id_ok_i, want.id_ok);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        status_due.push_back(apply_command(func_i, target_id_i, set_level_i,
                                           pulse_ms_i, counter_pin_i));
      end
      pending_o <= status_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_pulse_actuator_and_edge_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_actuator_and_edge_counter: testbench of the actuator/counter block
// Drives directed and random commands through the command channel under
// several idle and stall patterns, with a long receiver hold-off, while a
// separate checker predicts every status beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_pulse_actuator_and_edge_counter;

  localparam int unsigned NUM_OUTPUTS = 4;
  localparam int unsigned TICK_MS     = 100;

  // The limit leaves a wide margin over the slowest correct run, even with 83
  // percent idling on either side.
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_WAIT  = 8;

  // Function codes that the block does not define. They must change nothing.
  localparam logic [pace_pkg::PACE_FUNC_W-1:0] FUNC_SPARE_MIN = 3'd5;
  localparam logic [pace_pkg::PACE_FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
  localparam logic [pace_pkg::PACE_FUNC_W-1:0] FUNC_SPARE_MAX = 3'd7;

  localparam logic [pace_pkg::PACE_ID_W-1:0] ACT_ID_MIN = 3'd1;
  localparam logic [pace_pkg::PACE_ID_W-1:0] ACT_ID_MAX =
      pace_pkg::PACE_ID_W'(NUM_OUTPUTS);

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Every input of the block starts from a known value.
  logic                             in_valid  = 1'b0;
  logic [pace_pkg::PACE_FUNC_W-1:0] cmd_func  = '0;
  logic [pace_pkg::PACE_ID_W-1:0]   cmd_id    = '0;
  logic                             cmd_level = 1'b0;
  logic [pace_pkg::PACE_MS_W-1:0]   cmd_ms    = '0;
  logic                             cmd_pin   = 1'b0;
  logic                             out_stall = 1'b0;

  logic                            in_stall;
  logic                            out_valid;
  logic [pace_pkg::PACE_RES_W-1:0] actuator_levels;
  logic [pace_pkg::PACE_RES_W-1:0] pulsing_mask;
  logic [pace_pkg::PACE_CNT_W-1:0] event_total;
  logic                            id_ok;

  int unsigned fail_count;
  int unsigned pending;

  // Idling controls. The sender's idle share is used only by the stimulus
  // process; the stall share and the hold-off counter feed the stall process.
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned hold_cnt    = 0;
  int unsigned cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pulse_actuator_and_edge_counter #(
    .NUM_OUTPUTS(NUM_OUTPUTS),
    .TICK_MS    (TICK_MS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .func_i           (cmd_func),
    .target_id_i      (cmd_id),
    .set_level_i      (cmd_level),
    .pulse_ms_i       (cmd_ms),
    .counter_pin_i    (cmd_pin),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .actuator_levels_o(actuator_levels),
    .pulsing_mask_o   (pulsing_mask),
    .event_total_o    (event_total),
    .id_ok_o          (id_ok)
  );

  pace_status_checker #(
    .NUM_OUTPUTS(NUM_OUTPUTS),
    .TICK_MS    (TICK_MS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .func_i           (cmd_func),
    .target_id_i      (cmd_id),
    .set_level_i      (cmd_level),
    .pulse_ms_i       (cmd_ms),
    .counter_pin_i    (cmd_pin),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .actuator_levels_i(actuator_levels),
    .pulsing_mask_i   (pulsing_mask),
    .event_total_i    (event_total),
    .id_ok_i          (id_ok),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Receiver side. A long hold-off, once started by the stimulus process,
  // is counted down here and overrides the random stall. The stimulus only
  // writes hold_cnt while it is zero, so this process never writes it in the
  // same step.
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pulse_actuator_and_edge_counter: mismatch");
      $finish;
    end
  end

  // Offers one command beat and returns at the edge where it is accepted.
  // Random idle cycles go in front of the beat, so every call starts and ends
  // on a rising edge and valid changes at most once per edge.
  task automatic send_cmd(input logic [pace_pkg::PACE_FUNC_W-1:0] cmd,
                          input logic [pace_pkg::PACE_ID_W-1:0] id,
                          input logic lvl,
                          input logic [pace_pkg::PACE_MS_W-1:0] ms,
                          input logic pin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd_func  <= cmd;
    cmd_id    <= id;
    cmd_level <= lvl;
    cmd_ms    <= ms;
    cmd_pin   <= pin;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Random command. Most beats are well-formed commands on valid ids, with
  // ticks frequent enough that pulses run out; the rest are bad ids and the
  // undefined function codes. Fields that a command ignores are still random.
  task automatic send_random_cmd();
    int unsigned                      pick;
    logic [pace_pkg::PACE_FUNC_W-1:0] cmd;
    logic [pace_pkg::PACE_ID_W-1:0]   id;
    logic [pace_pkg::PACE_MS_W-1:0]   ms;
    pick = $urandom_range(99);
    if (pick < 35)      cmd = pace_pkg::FUNC_TICK;
    else if (pick < 50) cmd = pace_pkg::FUNC_SET;
    else if (pick < 62) cmd = pace_pkg::FUNC_TOGGLE;
    else if (pick < 80) cmd = pace_pkg::FUNC_PULSE;
    else if (pick < 94) cmd = pace_pkg::FUNC_CNT_RST;
    else cmd = pace_pkg::PACE_FUNC_W'($urandom_range(FUNC_SPARE_MAX, FUNC_SPARE_MIN));
    if (cmd == pace_pkg::FUNC_CNT_RST && $urandom_range(99) < 70) begin
      id = pace_pkg::PACE_CNT_ID;
    end else if ($urandom_range(99) < 85) begin
      id = pace_pkg::PACE_ID_W'($urandom_range(ACT_ID_MAX, ACT_ID_MIN));
    end else begin
      id = pace_pkg::PACE_ID_W'($urandom);
    end
    // Mostly short pulses so that they expire within a handful of ticks.
    pick = $urandom_range(99);
    if (pick < 60)      ms = pace_pkg::PACE_MS_W'($urandom_range(600));
    else if (pick < 85) ms = pace_pkg::PACE_MS_W'($urandom_range(3000));
    else                ms = pace_pkg::PACE_MS_W'($urandom);
    send_cmd(cmd, id, 1'($urandom), ms, 1'($urandom));
  endtask

  task automatic send_random_burst(input int unsigned count);
    repeat (count) send_random_cmd();
  endtask

  // Drops valid and waits until every predicted status beat has come back.
  // The first edge lets the checker's count catch up with the last beat.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling. Counter edges first, from the reset level of
    // one: no edge on a high sample, one edge on the first low sample.
    send_cmd(pace_pkg::FUNC_TICK, 3'd0, 1'b0, 16'h0000, 1'b1);
    send_cmd(pace_pkg::FUNC_TICK, 3'd7, 1'b1, 16'hFFFF, 1'b0);
    send_cmd(pace_pkg::FUNC_TICK, 3'd3, 1'b0, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_TICK, 3'd5, 1'b0, 16'h1234, 1'b1);
    // Set on the lowest and highest actuators, then on ids out of range.
    send_cmd(pace_pkg::FUNC_SET, ACT_ID_MIN, 1'b1, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_SET, ACT_ID_MAX, 1'b1, 16'hFFFF, 1'b1);
    send_cmd(pace_pkg::FUNC_SET, 3'd0, 1'b1, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_SET, 3'd5, 1'b1, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_SET, 3'd7, 1'b1, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_TOGGLE, 3'd2, 1'b0, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_TOGGLE, 3'd1, 1'b1, 16'h0000, 1'b0);
    // Pulses: zero and just under one tick both last one tick, the longest
    // input length, two ticks, and a pulse on an invalid id.
    send_cmd(pace_pkg::FUNC_PULSE, 3'd1, 1'b0, 16'd0, 1'b0);
    send_cmd(pace_pkg::FUNC_PULSE, 3'd2, 1'b0, 16'd99, 1'b0);
    send_cmd(pace_pkg::FUNC_PULSE, 3'd3, 1'b0, 16'hFFFF, 1'b0);
    send_cmd(pace_pkg::FUNC_PULSE, 3'd4, 1'b0, 16'd250, 1'b0);
    send_cmd(pace_pkg::FUNC_PULSE, 3'd6, 1'b1, 16'd500, 1'b0);
    send_cmd(pace_pkg::FUNC_TICK, 3'd1, 1'b0, 16'h0000, 1'b1);
    // Set and toggle cancel a running pulse.
    send_cmd(pace_pkg::FUNC_SET, 3'd3, 1'b0, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_TOGGLE, 3'd4, 1'b0, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_TICK, 3'd2, 1'b0, 16'h0000, 1'b0);
    // Counter reset with the counter id and with a wrong one.
    send_cmd(pace_pkg::FUNC_CNT_RST, 3'd2, 1'b0, 16'h0000, 1'b0);
    send_cmd(pace_pkg::FUNC_CNT_RST, pace_pkg::PACE_CNT_ID, 1'b0, 16'h0000, 1'b0);
    send_cmd(FUNC_SPARE_MIN, 3'd1, 1'b1, 16'd300, 1'b0);
    send_cmd(FUNC_SPARE_MID, 3'd2, 1'b1, 16'd300, 1'b0);
    send_cmd(FUNC_SPARE_MAX, 3'd1, 1'b1, 16'd300, 1'b0);

    send_random_burst(150);

    // Long receiver hold-off while the sender keeps offering back to back:
    // both registers fill and the block must stall its command channel.
    hold_cnt <= HOLD_CYCLES;
    send_random_burst(24);
    // The sender then pauses until every status beat is back.
    wait_drained();

    idle_pct = 83;
    send_random_burst(160);

    idle_pct = 0;
    stall_pct <= 83;
    send_random_burst(160);

    idle_pct = 37;
    stall_pct <= 37;
    send_random_burst(160);

    idle_pct = 0;
    stall_pct <= 0;
    send_random_burst(150);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("pulse_actuator_and_edge_counter: match");
    end else begin
      $display("pulse_actuator_and_edge_counter: mismatch");
    end
    $finish;
  end

endmodule

// ----- pulse_actuator_and_edge_counter.f -----
rtl/pace_pkg.sv
rtl/pace_actuators.sv
rtl/pace_edge_cnt.sv
rtl/pulse_actuator_and_edge_counter.sv
tb/sv/pace_status_checker.sv
tb/sv/tb_pulse_actuator_and_edge_counter.sv
